/* hw/rtl/imaadpcm_pkg.sv */
// ============================================================================
// IMA ADPCM codec package
// Widths, limits and the step and index adaptation tables of the codec.
// ============================================================================
`default_nettype none

package imaadpcm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int STEP_W     = 15;
   localparam int IDX_W      = 7;
   localparam int CODE_W     = 4;
   localparam int ERR_W      = 17;

   localparam logic [IDX_W-1:0] MAX_IDX    = 7'd88;
   localparam logic [IDX_W-1:0] STEP_COUNT = 7'd89;
   localparam logic [ERR_W-1:0] ERR_START  = 17'h10000;

   localparam logic signed [SAMPLE_W-1:0] PRED_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] PRED_MIN = 16'sh8000;

   localparam logic [STEP_W-1:0] STEP_TAB [89] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // Step size for an index; indices beyond the table read the last entry.
   function automatic logic [STEP_W-1:0] step_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] clamped;
      clamped = (idx > MAX_IDX) ? MAX_IDX : idx;
      return STEP_TAB[clamped];
   endfunction

   // Index adaptation after a code, clamped to the table range.
   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0]  idx,
                                                   input logic [CODE_W-1:0] code);
      logic signed [IDX_W+1:0] sum;
      logic signed [IDX_W+1:0] adj;
      logic [IDX_W-1:0]        clamped;
      clamped = (idx > MAX_IDX) ? MAX_IDX : idx;
      case (code[2:0])
         3'd4:    adj = 9'sd2;
         3'd5:    adj = 9'sd4;
         3'd6:    adj = 9'sd6;
         3'd7:    adj = 9'sd8;
         default: adj = -9'sd1;
      endcase
      sum = $signed({2'b00, clamped}) + adj;
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed({2'b00, MAX_IDX})) begin
         return MAX_IDX;
      end else begin
         return sum[IDX_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ima_adpcm_codec_top.sv */
// ============================================================================
// IMA ADPCM codec
// 4-bit IMA ADPCM encoder and decoder built around one shared quantizer step.
// ============================================================================
//
// This block encodes 16-bit PCM samples into 4-bit IMA ADPCM codes, or decodes
// codes back into samples, as selected by the one-bit mode register written
// through the csr channel; the user must write it only while the block is idle,
// which the block does not enforce. Each accepted item runs through a small
// sequencer that drives one shared compare-subtract unit: a load state reads
// the step size from the table and forms the difference, a step state produces
// the three magnitude bits (compare and subtract when encoding, taken from the
// code when decoding), a finish state adds the delta to the predictor with
// saturation, and a done state delivers the result item once the output
// register is free; no new item is accepted before the return to idle. An
// encode item with the block-start flag first runs the quantizer against a
// zero predictor for each of the 89 step indices, each followed by an error
// compare; the lowest index with the smallest reconstruction error wins and
// is reported in chosen_index with index_valid set. A decode item with the
// block-start flag loads the header predictor and index (clamped to 88) in its
// acceptance cycle and produces no result item. The result sits in an output
// register, so the next input item is accepted while a finished result still
// waits to be taken.
`default_nettype none

module ima_adpcm_codec_top (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data,        // codec_mode: 0 encode, 1 decode

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,       // [15:0] pcm_sample, [19:16] code_nibble,
                                             // [26:20] header_index, rest zero
   input  wire logic        req_tuser,       // block_start

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,       // [3:0] code_out, [19:4] sample_out,
                                             // [26:20] step_index_out,
                                             // [33:27] chosen_index, rest zero
   output logic             rsp_tuser        // index_valid
);

   import imaadpcm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_STEP,
      S_FIN,
      S_ERR,
      S_DONE
   } state_type;

   // Control and architectural state.
   state_type                    state_ff, state_in;
   logic                         mode_ff, mode_in;
   logic signed [SAMPLE_W-1:0]   pred_ff, pred_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [IDX_W-1:0]             cnt_ff, cnt_in;
   logic [ERR_W-1:0]             best_err_ff, best_err_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic                         srch_ff, srch_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Item registers and the working registers of the shared quantizer.
   logic                         start_ff, start_in;
   logic signed [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic [CODE_W-1:0]            nib_ff, nib_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [ERR_W-1:0]             mag_ff, mag_in;
   logic [ERR_W-1:0]             delta_ff, delta_in;
   logic [CODE_W-1:0]            code_ff, code_in;
   logic [1:0]                   k_ff, k_in;
   logic signed [SAMPLE_W-1:0]   npred_ff, npred_in;

   // Result register.
   logic [CODE_W-1:0]            out_code_ff, out_code_in;
   logic [SAMPLE_W-1:0]          out_sample_ff, out_sample_in;
   logic [IDX_W-1:0]             out_sidx_ff, out_sidx_in;
   logic [IDX_W-1:0]             out_chosen_ff, out_chosen_in;
   logic                         out_flag_ff, out_flag_in;

   // Datapath intermediates.
   logic [IDX_W-1:0]             cur_idx;
   logic signed [SAMPLE_W-1:0]   base_pred;
   logic [STEP_W-1:0]            tab_step;
   logic signed [ERR_W-1:0]      diff;
   logic [1:0]                   bitpos;
   logic                         take;
   logic signed [ERR_W:0]        sum;
   logic signed [ERR_W-1:0]      err;
   logic [ERR_W-1:0]             abs_err;
   logic                         better;
   logic [IDX_W-1:0]             hdr_idx;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_flag_ff;
   assign rsp_tdata  = {6'b0, out_chosen_ff, out_sidx_ff, out_sample_ff, out_code_ff};

   // During the start search the quantizer works from a zero predictor at the
   // index under test; otherwise from the running predictor and index.
   assign cur_idx   = srch_ff ? cnt_ff : idx_ff;
   assign base_pred = srch_ff ? '0 : pred_ff;
   assign tab_step  = step_of(cur_idx);
   assign diff      = $signed({sample_ff[SAMPLE_W-1], sample_ff})
                    - $signed({base_pred[SAMPLE_W-1], base_pred});
   assign bitpos    = 2'd2 - k_ff;
   assign take      = mode_ff ? nib_ff[bitpos] : (mag_ff >= {2'b00, step_ff});
   assign sum       = $signed({{2{base_pred[SAMPLE_W-1]}}, base_pred})
                    + (code_ff[3] ? -$signed({1'b0, delta_ff}) : $signed({1'b0, delta_ff}));
   assign err       = $signed({npred_ff[SAMPLE_W-1], npred_ff})
                    - $signed({sample_ff[SAMPLE_W-1], sample_ff});
   assign abs_err   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   assign better    = (abs_err < best_err_ff);
   assign hdr_idx   = (req_tdata[26:20] > MAX_IDX) ? MAX_IDX : req_tdata[26:20];

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      pred_in       = pred_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      best_err_in   = best_err_ff;
      best_idx_in   = best_idx_ff;
      srch_in       = srch_ff;
      rsp_valid_in  = rsp_valid_ff;
      start_in      = start_ff;
      sample_in     = sample_ff;
      nib_in        = nib_ff;
      step_in       = step_ff;
      mag_in        = mag_ff;
      delta_in      = delta_ff;
      code_in       = code_ff;
      k_in          = k_ff;
      npred_in      = npred_ff;
      out_code_in   = out_code_ff;
      out_sample_in = out_sample_ff;
      out_sidx_in   = out_sidx_ff;
      out_chosen_in = out_chosen_ff;
      out_flag_in   = out_flag_ff;

      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               start_in  = req_tuser;
               sample_in = $signed(req_tdata[15:0]);
               nib_in    = req_tdata[19:16];
               srch_in   = 1'b0;
               if (mode_ff && req_tuser) begin
                  // Decode header: load state, no result item.
                  pred_in = $signed(req_tdata[15:0]);
                  idx_in  = hdr_idx;
               end else if (!mode_ff && req_tuser) begin
                  pred_in     = '0;
                  cnt_in      = '0;
                  best_err_in = ERR_START;
                  best_idx_in = '0;
                  srch_in     = 1'b1;
                  state_in    = S_LOAD;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end

         S_LOAD: begin
            step_in  = tab_step;
            delta_in = {5'b0, tab_step[STEP_W-1:3]};
            mag_in   = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
            code_in  = {(mode_ff ? nib_ff[3] : diff[ERR_W-1]), 3'b000};
            k_in     = '0;
            state_in = S_STEP;
         end

         S_STEP: begin
            if (take) begin
               mag_in          = mag_ff - {2'b00, step_ff};
               delta_in        = delta_ff + {2'b00, step_ff};
               code_in[bitpos] = 1'b1;
            end
            step_in = step_ff >> 1;
            k_in    = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (sum > $signed({{3{PRED_MAX[SAMPLE_W-1]}}, PRED_MAX})) begin
               npred_in = PRED_MAX;
            end else if (sum < $signed({{3{PRED_MIN[SAMPLE_W-1]}}, PRED_MIN})) begin
               npred_in = PRED_MIN;
            end else begin
               npred_in = sum[SAMPLE_W-1:0];
            end
            state_in = srch_ff ? S_ERR : S_DONE;
         end

         S_ERR: begin
            // Strict compare keeps the lowest index on a tie.
            if (better) begin
               best_err_in = abs_err;
               best_idx_in = cnt_ff;
            end
            if (cnt_ff == MAX_IDX) begin
               srch_in = 1'b0;
               cnt_in  = STEP_COUNT;
               idx_in  = better ? cnt_ff : best_idx_ff;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
            state_in = S_LOAD;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               pred_in       = npred_ff;
               idx_in        = next_index(idx_ff, code_ff);
               out_code_in   = mode_ff ? '0 : code_ff;
               out_sample_in = npred_ff;
               out_sidx_in   = next_index(idx_ff, code_ff);
               out_flag_in   = start_ff && !mode_ff;
               out_chosen_in = (start_ff && !mode_ff) ? idx_ff : '0;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         pred_ff      <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         best_err_ff  <= '0;
         best_idx_ff  <= '0;
         srch_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pred_ff      <= pred_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         best_err_ff  <= best_err_in;
         best_idx_ff  <= best_idx_in;
         srch_ff      <= srch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff      <= start_in;
      sample_ff     <= sample_in;
      nib_ff        <= nib_in;
      step_ff       <= step_in;
      mag_ff        <= mag_in;
      delta_ff      <= delta_in;
      code_ff       <= code_in;
      k_ff          <= k_in;
      npred_ff      <= npred_in;
      out_code_ff   <= out_code_in;
      out_sample_ff <= out_sample_in;
      out_sidx_ff   <= out_sidx_in;
      out_chosen_ff <= out_chosen_in;
      out_flag_ff   <= out_flag_in;
   end

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// IMA ADPCM codec testbench
// Streams PCM samples and ADPCM codes through the codec in both modes and
// checks every result item against a cycle-free model of the codec.
// ============================================================================

module tb;
   import imaadpcm_pkg::*;

   // Mode register values. The port carries a single bit.
   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } codec_mode_type;

   // One input item, as the test sees it before packing onto the bus.
   typedef struct packed {
      logic                       start;
      logic signed [SAMPLE_W-1:0] pcm;
      logic [CODE_W-1:0]          nib;
      logic [IDX_W-1:0]           hidx;
   } codec_req_type;

   // One result item, unpacked from the bus.
   typedef struct packed {
      logic [CODE_W-1:0]          code;
      logic signed [SAMPLE_W-1:0] sample;
      logic [IDX_W-1:0]           step_idx;
      logic [IDX_W-1:0]           chosen;
      logic                       idx_valid;
   } codec_rsp_type;

   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 16;    // well past the longest ordinary item
   localparam int SEARCH_CYCLES = 541;   // encode start: search over all 89 indices plus one item
   localparam int ITEM_CYCLES   = 7;
   localparam int GAP_ALLOW     = 40;    // longest random gap we budget per side
   localparam int HOLD_CYCLES   = 300;
   localparam int TIMEOUT_BASE  = 20000;

   // Clock and reset. Inputs start at known values before the first edge.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic        csr_valid  = 1'b0;
   logic        csr_data   = 1'b0;
   logic        csr_ready;
   logic        req_tvalid = 1'b0;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   ima_adpcm_codec_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Items waiting to be offered, and results the codec still owes us.
   codec_req_type pending_inputs[$];
   codec_rsp_type expected_outputs[$];

   // Our own copy of the codec state and its mode register.
   codec_mode_type          cur_mode  = MODE_ENCODE;
   logic signed [SAMPLE_W-1:0] cur_pred  = '0;
   logic [IDX_W-1:0]        cur_index = '0;

   // Pacing knobs, set per phase by the stimulus process.
   int send_idle_pct   = 0;
   int rcv_stall_pct   = 0;
   int rsp_hold_cycles = 0;

   int cycle_count      = 0;
   int cycle_budget     = 0;
   int mismatch_count   = 0;
   int items_accepted   = 0;
   int starts_accepted  = 0;
   int results_checked  = 0;
   int searches_checked = 0;

   codec_req_type offered;
   codec_req_type req_item;
   logic          req_fired = 1'b0;
   codec_rsp_type got;
   codec_rsp_type want;

   // ------------------------------------------------------------------------
   // Codec arithmetic
   // ------------------------------------------------------------------------

   function automatic int clip16(input int v);
      if (v > int'(PRED_MAX)) return int'(PRED_MAX);
      if (v < int'(PRED_MIN)) return int'(PRED_MIN);
      return v;
   endfunction

   // Table reads clamp the index to the last entry.
   function automatic int step_size(input logic [IDX_W-1:0] idx);
      return int'(STEP_TAB[(idx > MAX_IDX) ? MAX_IDX : idx]);
   endfunction

   // Index adaptation: small magnitudes step down by one, large ones up by 2..8.
   function automatic logic [IDX_W-1:0] adapt_index(input logic [IDX_W-1:0] idx,
                                                    input logic [CODE_W-1:0] code);
      int n;
      n = (idx > MAX_IDX) ? int'(MAX_IDX) : int'(idx);
      if (code[2]) n = n + 2 * (int'(code[1:0]) + 1);
      else         n = n - 1;
      if (n < 0) n = 0;
      if (n > int'(MAX_IDX)) n = int'(MAX_IDX);
      return n[IDX_W-1:0];
   endfunction

   // Quantizes one sample against a predictor; also returns the reconstruction.
   function automatic logic [CODE_W-1:0] quantize_sample(input int sample, input int pred,
                                                         input logic [IDX_W-1:0] idx,
                                                         output int recon);
      int step;
      int diff;
      int delta;
      int k;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] bit_val;
      step    = step_size(idx);
      diff    = sample - pred;
      delta   = step >>> 3;
      code    = '0;
      bit_val = 4'd4;
      if (diff < 0) begin
         code = 4'd8;
         diff = -diff;
      end
      for (k = 0; k < 3; k++) begin
         if (diff >= step) begin
            code  = code | bit_val;
            diff  = diff - step;
            delta = delta + step;
         end
         step    = step >>> 1;
         bit_val = bit_val >> 1;
      end
      if (code[3]) delta = -delta;
      recon = clip16(pred + delta);
      return code;
   endfunction

   function automatic int reconstruct_sample(input logic [CODE_W-1:0] code, input int pred,
                                             input logic [IDX_W-1:0] idx);
      int step;
      int delta;
      step  = step_size(idx);
      delta = step >>> 3;
      if (code[2]) delta = delta + step;
      if (code[1]) delta = delta + (step >>> 1);
      if (code[0]) delta = delta + (step >>> 2);
      if (code[3]) delta = -delta;
      return clip16(pred + delta);
   endfunction

   // Advances our codec state by one accepted item and queues the result it owes.
   task automatic adpcm_step(input codec_req_type it);
      codec_rsp_type r;
      int recon;
      int err;
      int best_err;
      int i;
      logic [IDX_W-1:0] pick;
      r = '0;
      if (cur_mode == MODE_DECODE && it.start) begin
         // A decode header only loads state; nothing comes out for it.
         cur_pred  = it.pcm;
         cur_index = (it.hidx > MAX_IDX) ? MAX_IDX : it.hidx;
      end else begin
         if (cur_mode == MODE_DECODE) begin
            cur_pred  = 16'(reconstruct_sample(it.nib, int'(cur_pred), cur_index));
            cur_index = adapt_index(cur_index, it.nib);
         end else begin
            if (it.start) begin
               // Search every step index from a zero predictor; the first
               // strictly better error wins, so ties keep the lowest index.
               cur_pred = '0;
               best_err = int'(ERR_START);
               pick     = '0;
               for (i = 0; i < int'(STEP_COUNT); i++) begin
                  void'(quantize_sample(int'(it.pcm), 0, 7'(i), recon));
                  err = recon - int'(it.pcm);
                  if (err < 0) err = -err;
                  if (err < best_err) begin
                     best_err = err;
                     pick     = 7'(i);
                  end
               end
               cur_index   = pick;
               r.chosen    = pick;
               r.idx_valid = 1'b1;
            end
            r.code    = quantize_sample(int'(it.pcm), int'(cur_pred), cur_index, recon);
            cur_pred  = 16'(recon);
            cur_index = adapt_index(cur_index, r.code);
         end
         r.sample   = cur_pred;
         r.step_idx = cur_index;
         expected_outputs.push_back(r);
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic int random_pcm();
      return int'($signed(16'($urandom)));
   endfunction

   // Queues one item and widens the run-time budget by its worst-case cost.
   task automatic push_item(input bit start, input int pcm, input int nib, input int hidx);
      codec_req_type it;
      it.start = start;
      it.pcm   = 16'(pcm);
      it.nib   = 4'(nib);
      it.hidx  = 7'(hidx);
      pending_inputs.push_back(it);
      cycle_budget += ((start && cur_mode == MODE_ENCODE) ? SEARCH_CYCLES : ITEM_CYCLES)
                      + 2 * GAP_ALLOW;
   endtask

   // Encode blocks: mostly a start item and a run of samples, following a
   // random walk, full-range noise or swings out to the rails. Some blocks
   // have no start item and simply continue the previous state.
   task automatic queue_encode(input int n);
      int left;
      int len;
      int style;
      int amp;
      int s;
      int j;
      bit with_start;
      left = n;
      while (left > 0) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(8, 48);
         if (len > left) len = left;
         with_start = ($urandom_range(9) != 0);
         style      = $urandom_range(3);
         amp        = (style == 1) ? $urandom_range(1, 64) : $urandom_range(64, 4000);
         s          = random_pcm();
         for (j = 0; j < len; j++) begin
            if (style == 0) begin
               s = random_pcm();
            end else if (style == 3 && $urandom_range(3) == 0) begin
               s = $urandom_range(1) ? int'(PRED_MAX) : int'(PRED_MIN);
            end else begin
               s = clip16(s + int'($urandom_range(2 * amp)) - amp);
            end
            push_item(with_start && j == 0, s, $urandom_range(15), $urandom_range(127));
         end
         left -= len;
      end
   endtask

   // Decode blocks: mostly a header item, then codes. Some blocks lean to small
   // magnitudes (index sinks to zero), some to large ones (index climbs to
   // the top and the predictor hits the rails).
   task automatic queue_decode(input int n);
      int left;
      int len;
      int style;
      int j;
      bit with_start;
      logic [CODE_W-1:0] nib;
      left = n;
      while (left > 0) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(8, 48);
         if (len > left) len = left;
         with_start = ($urandom_range(9) != 0);
         style      = $urandom_range(2);
         for (j = 0; j < len; j++) begin
            nib = 4'($urandom_range(15));
            if (style == 1) nib[2] = 1'b0;
            if (style == 2) nib[2] = 1'b1;
            push_item(with_start && j == 0, random_pcm(), nib, $urandom_range(127));
         end
         left -= len;
      end
   endtask

   // Writes the mode register; the block is idle whenever this is called.
   task automatic write_mode(input codec_mode_type m);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      cur_mode = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Holds off until every queued item is taken and every result is back,
   // then lets the block settle before the next register write.
   task automatic wait_idle();
      while (pending_inputs.size() != 0 || req_tvalid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Driver: acceptance is seen at the rising edge, the next item is put on
   // the bus at the falling edge. An item stays on the bus until taken.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      req_fired <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         items_accepted++;
         if (req_item.start) starts_accepted++;
         adpcm_step(req_item);
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fired)) begin
         if (pending_inputs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offered = pending_inputs.pop_front();
            req_item   <= offered;
            req_tvalid <= 1'b1;
            req_tdata  <= {5'b0, offered.hidx, offered.nib, offered.pcm};
            req_tuser  <= offered.start;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off counted down here when the
   // stimulus process asks for one.
   // ------------------------------------------------------------------------

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every result taken is checked against the oldest expectation.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.code      = rsp_tdata[3:0];
         got.sample    = rsp_tdata[19:4];
         got.step_idx  = rsp_tdata[26:20];
         got.chosen    = rsp_tdata[33:27];
         got.idx_valid = rsp_tuser;
         results_checked++;
         if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      results_checked));
         end else begin
            want = expected_outputs.pop_front();
            if (want.idx_valid) searches_checked++;
            if (got.code != want.code)
               report_mismatch($sformatf("result %0d code_out: got %0d, expected %0d",
                                         results_checked, got.code, want.code));
            if (got.sample != want.sample)
               report_mismatch($sformatf("result %0d sample_out: got %0d, expected %0d",
                                         results_checked, got.sample, want.sample));
            if (got.step_idx != want.step_idx)
               report_mismatch($sformatf("result %0d step_index_out: got %0d, expected %0d",
                                         results_checked, got.step_idx, want.step_idx));
            if (got.chosen != want.chosen)
               report_mismatch($sformatf("result %0d chosen_index: got %0d, expected %0d",
                                         results_checked, got.chosen, want.chosen));
            if (got.idx_valid != want.idx_valid)
               report_mismatch($sformatf("result %0d index_valid: got %0d, expected %0d",
                                         results_checked, got.idx_valid, want.idx_valid));
         end
      end
   end

   // Watchdog. The budget grows with every queued item by that item's worst
   // case, and the limit allows four times that plus fixed overhead.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_BASE + HOLD_CYCLES + 4 * cycle_budget) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus: directed items first, then random phases with varied pacing.
   // ------------------------------------------------------------------------

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Encode corners. The first items run before any start, from the
      // reset state. A zero start ties across many indices and must keep the
      // lowest; the rail samples drive the predictor into saturation.
      write_mode(MODE_ENCODE);
      push_item(0, 0, $urandom_range(15), $urandom_range(127));
      push_item(0, 32767, $urandom_range(15), $urandom_range(127));
      push_item(0, -32768, $urandom_range(15), $urandom_range(127));
      push_item(1, 0, $urandom_range(15), $urandom_range(127));
      push_item(0, 32767, $urandom_range(15), $urandom_range(127));
      push_item(0, 32767, $urandom_range(15), $urandom_range(127));
      push_item(0, 32767, $urandom_range(15), $urandom_range(127));
      push_item(1, -32768, $urandom_range(15), $urandom_range(127));
      push_item(0, -32768, $urandom_range(15), $urandom_range(127));
      push_item(0, 32767, $urandom_range(15), $urandom_range(127));
      push_item(1, 32767, $urandom_range(15), $urandom_range(127));
      push_item(1, 1, $urandom_range(15), $urandom_range(127));
      push_item(1, -1, $urandom_range(15), $urandom_range(127));
      wait_idle();

      // Decode corners: a header index past the table end is clamped, codes
      // push the predictor into both rails and the index against both ends.
      write_mode(MODE_DECODE);
      push_item(1, 32767, $urandom_range(15), 127);
      push_item(0, random_pcm(), 7, $urandom_range(127));
      push_item(0, random_pcm(), 7, $urandom_range(127));
      push_item(1, -32768, $urandom_range(15), 0);
      push_item(0, random_pcm(), 15, $urandom_range(127));
      push_item(0, random_pcm(), 8, $urandom_range(127));
      push_item(0, random_pcm(), 0, $urandom_range(127));
      push_item(1, 0, $urandom_range(15), 88);
      push_item(0, random_pcm(), 7, $urandom_range(127));
      push_item(0, random_pcm(), 3, $urandom_range(127));
      push_item(0, random_pcm(), 12, $urandom_range(127));
      push_item(0, random_pcm(), 4, $urandom_range(127));
      push_item(0, random_pcm(), 11, $urandom_range(127));
      wait_idle();

      // Free flow in both directions. The encode phase is split by a full
      // drain, so the sender sits idle with nothing in flight once.
      write_mode(MODE_ENCODE);
      queue_encode(100);
      wait_idle();
      queue_encode(100);
      wait_idle();
      write_mode(MODE_DECODE);
      queue_decode(200);
      wait_idle();

      // Sender gaps only.
      write_mode(MODE_ENCODE);
      send_idle_pct = 53;
      queue_encode(200);
      wait_idle();

      // Output stalls, opening with a long hold-off while the sender keeps
      // offering, so the result register fills and the input backs up.
      write_mode(MODE_DECODE);
      send_idle_pct   = 0;
      rcv_stall_pct   = 53;
      rsp_hold_cycles = HOLD_CYCLES;
      queue_decode(200);
      wait_idle();
      write_mode(MODE_ENCODE);
      queue_encode(200);
      wait_idle();

      // Light pacing on both sides.
      write_mode(MODE_DECODE);
      send_idle_pct = 9;
      rcv_stall_pct = 9;
      queue_decode(200);
      wait_idle();
      write_mode(MODE_ENCODE);
      queue_encode(200);
      wait_idle();

      $display("summary: %0d items accepted (%0d with block start), %0d results checked,",
               items_accepted, starts_accepted, results_checked);
      $display("summary: %0d start searches; both modes, free flow, gaps, stalls, long hold",
               searches_checked);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* ima_adpcm_codec_top.f */
hw/rtl/imaadpcm_pkg.sv
hw/rtl/ima_adpcm_codec_top.sv
test/tb.sv
